@@ sv/mecanum_wheel_duty_mapper_top_defines.svh @@
// assertion macros shared by the duty mapper checker
`ifndef MECANUM_WHEEL_DUTY_MAPPER_TOP_DEFINES_SVH
`define MECANUM_WHEEL_DUTY_MAPPER_TOP_DEFINES_SVH

// property that must hold on every clock edge outside reset
`define MWDM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("duty mapper check failed");

// condition on one edge implies a condition on the next edge
`define MWDM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("duty mapper check failed");

`endif

@@ sv/mwdm_pkg.sv @@
// types, constants and register codes for the mecanum duty mapper
package mwdm_pkg;

    // field widths
    localparam int VEL_W       = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DUTY_W      = 10;
    localparam int AGE_W       = 8;
    localparam int MIN_DUTY_W  = 10;
    localparam int MASK_W      = 4;
    localparam int NUM_WHEELS  = 4;
    localparam int WHEEL_IDX_W = 2;

    // datapath widths: L*w fits 17 bits, wheel sums 18 bits, magnitudes 17 bits
    localparam int LW_W   = 17;
    localparam int SUM_W  = 18;
    localparam int MAG_W  = 17;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // duty full scale, never above the field range
    localparam int DUTY_BITS  = 10;
    localparam int DUTY_FULL  = (1 << DUTY_BITS) - 1;
    localparam int FIELD_MAX  = (1 << DUTY_W) - 1;
    localparam int DUTY_CAP   = (DUTY_FULL < FIELD_MAX) ? DUTY_FULL : FIELD_MAX;

    // request kinds
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_TICK  = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVER_ARM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DUTY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_MASK = 3'd4;

    // register reset values
    localparam logic [15:0]           RST_LEVER_ARM   = 16'd26634;
    localparam logic [15:0]           RST_DUTY_GAIN   = 16'd31435;
    localparam logic [MIN_DUTY_W-1:0] RST_MIN_DUTY    = 10'd204;
    localparam logic [AGE_W-1:0]      RST_TIMEOUT     = 8'd25;
    localparam logic [MASK_W-1:0]     RST_INVERT_MASK = 4'd10;

    typedef struct packed {
        logic [15:0]           lever_arm;
        logic [15:0]           duty_gain;
        logic [MIN_DUTY_W-1:0] min_duty;
        logic [AGE_W-1:0]      timeout_ticks;
        logic [MASK_W-1:0]     invert_mask;
    } t_cfg;

    // one control tick handed from front to back
    typedef struct packed {
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        logic signed [VEL_W-1:0] yaw;
        logic                    timed_out;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_fl;
        logic [DUTY_W-1:0] duty_fr;
        logic [DUTY_W-1:0] duty_rl;
        logic [DUTY_W-1:0] duty_rr;
        logic              fwd_fl;
        logic              fwd_fr;
        logic              fwd_rl;
        logic              fwd_rr;
        logic              timed_out;
    } t_result;

endpackage

@@ sv/mwdm_front.sv @@
// front end: takes requests, keeps the held command and its age, queues ticks
module mwdm_front
    import mwdm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_cmd,
    input  logic signed [VEL_W-1:0] i_vx,
    input  logic signed [VEL_W-1:0] i_vy,
    input  logic signed [VEL_W-1:0] i_yaw,
    input  logic [AGE_W-1:0]        i_timeout,
    input  t_q_status               i_q_status,
    output logic                    o_stall,
    output logic                    o_push,
    output t_job                    o_job
);

    logic signed [VEL_W-1:0] r_held_vx, n_held_vx;
    logic signed [VEL_W-1:0] r_held_vy, n_held_vy;
    logic signed [VEL_W-1:0] r_held_yaw, n_held_yaw;
    logic [AGE_W-1:0]        r_age, n_age;
    logic                    accept;
    logic [AGE_W-1:0]        age_inc;
    logic                    expired;

    // stall while the queue has no room
    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !o_stall;

    // saturating age and timeout test
    assign age_inc = (r_age == {AGE_W{1'b1}}) ? r_age : r_age + 1'b1;
    assign expired = age_inc > i_timeout;

    always_comb begin
        n_held_vx  = r_held_vx;
        n_held_vy  = r_held_vy;
        n_held_yaw = r_held_yaw;
        n_age      = r_age;
        o_push     = 1'b0;
        if (accept) begin
            if (i_cmd == CMD_WRITE) begin
                n_held_vx  = i_vx;
                n_held_vy  = i_vy;
                n_held_yaw = i_yaw;
                n_age      = '0;
            end else begin
                n_age  = age_inc;
                o_push = 1'b1;
                if (expired) begin
                    n_held_vx  = '0;
                    n_held_vy  = '0;
                    n_held_yaw = '0;
                end
            end
        end
    end

    // tick request carries the command as it stands after the timeout test
    assign o_job = '{vx: n_held_vx, vy: n_held_vy, yaw: n_held_yaw, timed_out: expired};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_vx  <= '0;
            r_held_vy  <= '0;
            r_held_yaw <= '0;
            r_age      <= '0;
        end else begin
            r_held_vx  <= n_held_vx;
            r_held_vy  <= n_held_vy;
            r_held_yaw <= n_held_yaw;
            r_age      <= n_age;
        end
    end

endmodule

@@ sv/mwdm_queue.sv @@
// short request queue between front and back
module mwdm_queue
    import mwdm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_job      i_job,
    input  logic      i_pop,
    output t_job      o_job,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full  = r_count == CNT_W'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_job          = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ sv/mwdm_back.sv @@
// back end: lever-arm product, then wheel sums and duty one wheel at a time, result register
module mwdm_back
    import mwdm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  t_q_status i_q_status,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_result   o_result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LW,
        S_SUM,
        S_DUTY,
        S_DONE
    } t_state;

    localparam logic [WHEEL_IDX_W-1:0] LAST_WHEEL = WHEEL_IDX_W'(NUM_WHEELS - 1);
    localparam logic [MAG_W-1:0]       CAP        = MAG_W'(DUTY_CAP);

    t_state                   r_state;
    t_job                     r_job;
    logic signed [LW_W-1:0]   r_lw;
    logic [WHEEL_IDX_W-1:0]   r_wheel;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic                     r_nz;
    logic [DUTY_W-1:0]        r_duty [NUM_WHEELS];
    logic [NUM_WHEELS-1:0]    r_fwd;
    logic                     r_out_valid;
    t_result                  r_result;

    logic signed [2*VEL_W:0]  lw_prod;
    logic signed [SUM_W-1:0]  vx_ext, vy_ext, lw_ext, vy_term, lw_term, sum;
    logic [SUM_W-1:0]         sum_abs;
    logic [MAG_W+15:0]        duty_prod;
    logic [MAG_W-1:0]         duty_raw, duty_min, duty_fin;
    logic                     out_free;

    assign o_pop       = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign out_free    = !r_out_valid || !i_out_stall;

    // yaw times lever arm, upper bits give the floor of the scaled product
    assign lw_prod = r_job.yaw * $signed({1'b0, i_cfg.lever_arm});

    // wheel sum: front left vx-vy-lw, front right vx+vy+lw,
    // rear left vx+vy-lw, rear right vx-vy+lw
    always_comb begin
        vx_ext = SUM_W'(r_job.vx);
        vy_ext = SUM_W'(r_job.vy);
        lw_ext = SUM_W'(r_lw);
        case (r_wheel)
            2'd0:    begin vy_term = -vy_ext; lw_term = -lw_ext; end
            2'd1:    begin vy_term =  vy_ext; lw_term =  lw_ext; end
            2'd2:    begin vy_term =  vy_ext; lw_term = -lw_ext; end
            default: begin vy_term = -vy_ext; lw_term =  lw_ext; end
        endcase
        sum     = vx_ext + vy_term + lw_term;
        sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    end

    // duty: truncated product, raised to the minimum when nonzero, then capped
    always_comb begin
        duty_prod = r_mag * i_cfg.duty_gain;
        duty_raw  = duty_prod[MAG_W+15:16];
        duty_min  = (r_nz && (duty_raw < MAG_W'(i_cfg.min_duty)))
                    ? MAG_W'(i_cfg.min_duty) : duty_raw;
        duty_fin  = (duty_min > CAP) ? CAP : duty_min;
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_wheel <= '0;
                        r_state <= S_LW;
                    end
                end
                S_LW: begin
                    r_lw    <= lw_prod[2*VEL_W:VEL_W];
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_mag   <= sum_abs[MAG_W-1:0];
                    r_neg   <= sum[SUM_W-1];
                    r_nz    <= sum != '0;
                    r_state <= S_DUTY;
                end
                S_DUTY: begin
                    r_duty[r_wheel] <= duty_fin[DUTY_W-1:0];
                    r_fwd[r_wheel]  <= !r_neg ^ i_cfg.invert_mask[r_wheel];
                    if (r_wheel == LAST_WHEEL) begin
                        r_state <= S_DONE;
                    end else begin
                        r_wheel <= r_wheel + 1'b1;
                        r_state <= S_SUM;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_result.duty_fl   <= r_duty[0];
                        r_result.duty_fr   <= r_duty[1];
                        r_result.duty_rl   <= r_duty[2];
                        r_result.duty_rr   <= r_duty[3];
                        r_result.fwd_fl    <= r_fwd[0];
                        r_result.fwd_fr    <= r_fwd[1];
                        r_result.fwd_rl    <= r_fwd[2];
                        r_result.fwd_rr    <= r_fwd[3];
                        r_result.timed_out <= r_job.timed_out;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ sv/mecanum_wheel_duty_mapper_top.sv @@
// top level of the mecanum wheel duty mapper
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------
//  request  | i_in_valid / o_in_stall    | i_cmd, i_velocity_x/y, i_yaw_rate
//  result   | o_out_valid / i_out_stall  | o_duty_*, o_fwd_*, o_timed_out
//  config   | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// a velocity write is absorbed by the front end and gives no result
// a control tick goes through the back end as fetch, L*w, a sum and a duty step
// per wheel, then a load of the result register once the output is not stalled
// the queue holds QUEUE_DEPTH_P ticks; o_in_stall rises only when it is full
// synchronous reset restores register defaults and clears the held command
module mecanum_wheel_duty_mapper_top
    import mwdm_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic                    i_cmd,
    input  logic signed [VEL_W-1:0] i_velocity_x,
    input  logic signed [VEL_W-1:0] i_velocity_y,
    input  logic signed [VEL_W-1:0] i_yaw_rate,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [DUTY_W-1:0]       o_duty_front_left,
    output logic [DUTY_W-1:0]       o_duty_front_right,
    output logic [DUTY_W-1:0]       o_duty_rear_left,
    output logic [DUTY_W-1:0]       o_duty_rear_right,
    output logic                    o_fwd_front_left,
    output logic                    o_fwd_front_right,
    output logic                    o_fwd_rear_left,
    output logic                    o_fwd_rear_right,
    output logic                    o_timed_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data
);

    t_cfg      r_cfg;
    t_job      front_job, queue_job;
    t_q_status q_status;
    t_result   result;
    logic      push, pop;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lever_arm     <= RST_LEVER_ARM;
            r_cfg.duty_gain     <= RST_DUTY_GAIN;
            r_cfg.min_duty      <= RST_MIN_DUTY;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
            r_cfg.invert_mask   <= RST_INVERT_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEVER_ARM:   r_cfg.lever_arm     <= i_cfg_data;
                CFG_DUTY_GAIN:   r_cfg.duty_gain     <= i_cfg_data;
                CFG_MIN_DUTY:    r_cfg.min_duty      <= i_cfg_data[MIN_DUTY_W-1:0];
                CFG_TIMEOUT:     r_cfg.timeout_ticks <= i_cfg_data[AGE_W-1:0];
                CFG_INVERT_MASK: r_cfg.invert_mask   <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    mwdm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_cmd      (i_cmd),
        .i_vx       (i_velocity_x),
        .i_vy       (i_velocity_y),
        .i_yaw      (i_yaw_rate),
        .i_timeout  (r_cfg.timeout_ticks),
        .i_q_status (q_status),
        .o_stall    (o_in_stall),
        .o_push     (push),
        .o_job      (front_job)
    );

    mwdm_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (queue_job),
        .o_status (q_status)
    );

    mwdm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (q_status),
        .i_job       (queue_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (result)
    );

    // result fields
    assign o_duty_front_left  = result.duty_fl;
    assign o_duty_front_right = result.duty_fr;
    assign o_duty_rear_left   = result.duty_rl;
    assign o_duty_rear_right  = result.duty_rr;
    assign o_fwd_front_left   = result.fwd_fl;
    assign o_fwd_front_right  = result.fwd_fr;
    assign o_fwd_rear_left    = result.fwd_rl;
    assign o_fwd_rear_right   = result.fwd_rr;
    assign o_timed_out        = result.timed_out;

endmodule

@@ sv/mwdm_checker.sv @@
// port-level checks for the duty mapper, bound to the top level
`include "mecanum_wheel_duty_mapper_top_defines.svh"

module mwdm_checker
    import mwdm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [DUTY_W-1:0] o_duty_front_left,
    input logic [DUTY_W-1:0] o_duty_front_right,
    input logic [DUTY_W-1:0] o_duty_rear_left,
    input logic [DUTY_W-1:0] o_duty_rear_right,
    input logic              o_fwd_front_left,
    input logic              o_fwd_front_right,
    input logic              o_fwd_rear_left,
    input logic              o_fwd_rear_right,
    input logic              o_timed_out
);

    localparam logic [DUTY_W-1:0] CAP = DUTY_W'(DUTY_CAP);

    logic [4*DUTY_W+4:0] out_bits;
    logic                duty_in_range;
    logic                duties_zero;

    // whole result payload
    assign out_bits = {o_duty_front_left, o_duty_front_right, o_duty_rear_left,
                       o_duty_rear_right, o_fwd_front_left, o_fwd_front_right,
                       o_fwd_rear_left, o_fwd_rear_right, o_timed_out};

    // every wheel within full scale
    assign duty_in_range = (o_duty_front_left <= CAP) && (o_duty_front_right <= CAP) &&
                           (o_duty_rear_left <= CAP) && (o_duty_rear_right <= CAP);

    // every wheel stopped
    assign duties_zero = (o_duty_front_left == '0) && (o_duty_front_right == '0) &&
                         (o_duty_rear_left == '0) && (o_duty_rear_right == '0);

    // a stalled result stays and keeps its payload
    `MWDM_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_bits))

    // no wheel exceeds full scale
    `MWDM_ASSERT(a_duty_cap, !o_out_valid || duty_in_range)

    // a timed out command drives every wheel to zero
    `MWDM_ASSERT(a_timeout_zero, !(o_out_valid && o_timed_out) || duties_zero)

endmodule

bind mecanum_wheel_duty_mapper_top mwdm_checker u_mwdm_checker (.*);
